@@ rtl/core/line_or_json_frame_detector_unit_defines.svh @@
// Assertion macros used by the frame detector RTL.
// Each macro expects clk and rst in the scope where it is used.
`ifndef LINE_OR_JSON_FRAME_DETECTOR_UNIT_DEFINES_SVH
`define LINE_OR_JSON_FRAME_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LOFD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LOFD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/lofd_pkg.sv @@
`default_nettype none

package lofd_pkg;

  // Size of the external frame buffer; the length limit never exceeds its last index.
  localparam int BUFFER_BYTES = 2048;
  localparam logic [10:0] LIMIT_CAP =
    (BUFFER_BYTES - 1 > 2047) ? 11'd2047 : 11'(BUFFER_BYTES - 1);

  // Frame modes.
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_LINE = 2'd1;
  localparam logic [1:0] MODE_JSON = 2'd2;

  // Result events.
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_LINE     = 3'd1;
  localparam logic [2:0] EV_JSON     = 3'd2;
  localparam logic [2:0] EV_OVERFLOW = 3'd3;
  localparam logic [2:0] EV_TIMEOUT  = 3'd4;

  // Input actions.
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_LIMIT   = 2'd1;

  // Configuration reset values.
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [10:0] LIMIT_RESET   = 11'd2047;

  // Saturation points.
  localparam logic [10:0] LEVEL_MAX = 11'h7FF;
  localparam logic [15:0] IDLE_MAX  = 16'hFFFF;

  // Characters of interest.
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Per-frame tracking state.
  typedef struct packed {
    logic [1:0]  mode;
    logic [10:0] length;
    logic [10:0] brace_level;
    logic [10:0] bracket_level;
    logic        quoted;
    logic [7:0]  last_byte;
    logic [15:0] idle_count;
  } frame_state_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  event_res;
    logic        byte_kept;
    logic [7:0]  data_byte;
    logic [10:0] frame_length;
    logic [1:0]  frame_mode;
  } frame_result_t;

  // Space, tab, LF, VT, FF and CR are whitespace.
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/lofd_step.sv @@
`default_nettype none

module lofd_step (
  input  wire lofd_pkg::frame_state_t  st,
  input  wire logic                    action,
  input  wire logic [7:0]              rx_byte,
  input  wire logic [15:0]             timeout_ticks,
  input  wire logic [10:0]             frame_limit,
  output lofd_pkg::frame_state_t       st_next,
  output lofd_pkg::frame_result_t      res
);
  import lofd_pkg::*;

  logic [10:0] limit;
  logic [10:0] length_inc;
  logic [1:0]  mode_d;
  logic        quoted_d;
  logic [10:0] brace_d;
  logic [10:0] bracket_d;

  // The limit is capped at the last index of the frame buffer.
  assign limit      = (frame_limit > LIMIT_CAP) ? LIMIT_CAP : frame_limit;
  assign length_inc = st.length + 11'd1;

  // The first non-whitespace byte decides the mode.
  assign mode_d = ((st.mode == MODE_NONE) && !is_space(rx_byte)) ?
                  (((rx_byte == CH_LBRACE) || (rx_byte == CH_LBRACK)) ? MODE_JSON : MODE_LINE) :
                  st.mode;

  // An unescaped quote toggles string mode.
  assign quoted_d = st.quoted ^ ((rx_byte == CH_QUOTE) && (st.last_byte != CH_BSLASH));

  // Depth counters move only outside strings, saturating at both ends.
  always_comb begin
    brace_d   = st.brace_level;
    bracket_d = st.bracket_level;
    if (!quoted_d) begin
      case (rx_byte)
        CH_LBRACE: if (st.brace_level != LEVEL_MAX) brace_d = st.brace_level + 11'd1;
        CH_RBRACE: if (st.brace_level != 11'd0) brace_d = st.brace_level - 11'd1;
        CH_LBRACK: if (st.bracket_level != LEVEL_MAX) bracket_d = st.bracket_level + 11'd1;
        CH_RBRACK: if (st.bracket_level != 11'd0) bracket_d = st.bracket_level - 11'd1;
        default: ;
      endcase
    end
  end

  // Next state and result for one item.
  always_comb begin
    st_next          = st;
    res.event_res    = EV_NONE;
    res.byte_kept    = 1'b0;
    res.data_byte    = (action == ACT_TICK) ? 8'd0 : rx_byte;
    res.frame_length = st.length;
    if (action == ACT_TICK) begin
      if ((st.mode == MODE_JSON) && (st.length != 11'd0) &&
          (st.idle_count >= timeout_ticks)) begin
        res.event_res = EV_TIMEOUT;
        st_next       = '0;
      end else if (st.idle_count != IDLE_MAX) begin
        st_next.idle_count = st.idle_count + 16'd1;
      end
    end else if (rx_byte != CH_CR) begin
      st_next.idle_count = 16'd0;
      if (st.length >= limit) begin
        res.event_res = EV_OVERFLOW;
        st_next       = '0;
      end else begin
        st_next.length   = length_inc;
        st_next.mode     = mode_d;
        res.byte_kept    = 1'b1;
        res.frame_length = length_inc;
        if (mode_d == MODE_LINE) begin
          if (rx_byte == CH_LF) begin
            res.event_res = EV_LINE;
            st_next       = '0;
          end
        end else if (mode_d == MODE_JSON) begin
          st_next.quoted        = quoted_d;
          st_next.brace_level   = brace_d;
          st_next.bracket_level = bracket_d;
          st_next.last_byte     = rx_byte;
          if (!quoted_d && (brace_d == 11'd0) && (bracket_d == 11'd0)) begin
            res.event_res = EV_JSON;
            st_next       = '0;
          end
        end
      end
    end
    res.frame_mode = st_next.mode;
  end

endmodule

`default_nettype wire

@@ rtl/core/line_or_json_frame_detector_unit.sv @@
// Latency: a result is valid in the cycle after its item is accepted.
// Throughput: one item per clock; the frame state updates in the accepting cycle.
// The single result register stalls input only while it holds an untaken result.
// Reset (rst, synchronous, active high) clears the frame state and the output valid,
// and returns timeout_ticks to 1000 and frame_limit to 2047.
`default_nettype none
`include "line_or_json_frame_detector_unit_defines.svh"

module line_or_json_frame_detector_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        action,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       event_res,
  output logic             byte_kept,
  output logic [7:0]       data_byte,
  output logic [10:0]      frame_length,
  output logic [1:0]       frame_mode,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import lofd_pkg::*;

  frame_state_t  st;
  frame_state_t  st_next;
  frame_result_t res;
  frame_result_t res_q;
  logic [15:0]   timeout_ticks;
  logic [10:0]   frame_limit;
  logic          in_fire;

  // A new transaction is taken whenever the result register is free or draining.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      frame_limit   <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT: timeout_ticks <= cfg_data;
        CFG_LIMIT:   frame_limit   <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  lofd_step u_step (
    .st            (st),
    .action        (action),
    .rx_byte       (rx_byte),
    .timeout_ticks (timeout_ticks),
    .frame_limit   (frame_limit),
    .st_next       (st_next),
    .res           (res)
  );

  // Frame state advances on every accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_q <= res;
    end
  end

  assign event_res    = res_q.event_res;
  assign byte_kept    = res_q.byte_kept;
  assign data_byte    = res_q.data_byte;
  assign frame_length = res_q.frame_length;
  assign frame_mode   = res_q.frame_mode;

  // An accepted transaction always leaves a result waiting.
  `LOFD_ASSERT_NXT(a_fire_gives_result, in_fire, out_valid, "accepted item produced no result")
  // Any frame event ends the frame, so the reported mode is undecided.
  `LOFD_ASSERT_IMP(a_event_clears_mode, out_valid && (event_res != EV_NONE),
    frame_mode == MODE_NONE, "frame event left a mode set")
  // An overflowing byte is never kept.
  `LOFD_ASSERT_IMP(a_overflow_drops, out_valid && (event_res == EV_OVERFLOW),
    !byte_kept, "overflow byte was kept")
  // Outside JSON mode no depth or string tracking survives.
  `LOFD_ASSERT_IMP(a_idle_tracking_clear, st.mode != MODE_JSON,
    (st.brace_level == 11'd0) && (st.bracket_level == 11'd0) && !st.quoted,
    "JSON tracking active outside JSON mode")

endmodule

`default_nettype wire

@@ sim/line_or_json_frame_detector_unit_tb.sv @@
`default_nettype none

module line_or_json_frame_detector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lofd_pkg::*;

  localparam int STALL_LIMIT = 2000;

  // Tracks the framing state of the stream and holds the results still due.
  class frame_event_board;
    frame_state_t st;
    logic [15:0] idle_limit;
    logic [10:0] len_limit;
    frame_result_t due_results[$];
    int mismatch_count;

    function new();
      st = '0;
      idle_limit = TIMEOUT_RESET;
      len_limit = LIMIT_RESET;
      mismatch_count = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      if (idx == CFG_TIMEOUT) begin
        idle_limit = val;
      end else if (idx == CFG_LIMIT) begin
        len_limit = val[10:0];
      end
    endfunction

    function bit blank(logic [7:0] b);
      return b inside {CH_SPACE, [CH_TAB:CH_CR]};
    endfunction

    // Works out the result of one accepted transaction and updates the frame state.
    function void note_item(logic act, logic [7:0] b);
      frame_result_t res;
      logic [10:0] cap;
      res = '0;
      cap = (len_limit > LIMIT_CAP) ? LIMIT_CAP : len_limit;
      if (act == ACT_TICK) begin
        res.frame_length = st.length;
        if (st.mode == MODE_JSON && st.length != 0 && st.idle_count >= idle_limit) begin
          res.event_res = EV_TIMEOUT;
          st = '0;
        end else if (st.idle_count != IDLE_MAX) begin
          st.idle_count++;
        end
      end else if (b == CH_CR) begin
        // A carriage return is echoed but leaves the frame untouched.
        res.data_byte = b;
        res.frame_length = st.length;
      end else begin
        res.data_byte = b;
        st.idle_count = 0;
        if (st.length >= cap) begin
          res.event_res = EV_OVERFLOW;
          res.frame_length = st.length;
          st = '0;
        end else begin
          st.length++;
          res.byte_kept = 1'b1;
          res.frame_length = st.length;
          if (st.mode == MODE_NONE && !blank(b)) begin
            st.mode = (b == CH_LBRACE || b == CH_LBRACK) ? MODE_JSON : MODE_LINE;
          end
          if (st.mode == MODE_LINE) begin
            if (b == CH_LF) begin
              res.event_res = EV_LINE;
              st = '0;
            end
          end else if (st.mode == MODE_JSON) begin
            if (b == CH_QUOTE && st.last_byte != CH_BSLASH) begin
              st.quoted = !st.quoted;
            end
            if (!st.quoted) begin
              if (b == CH_LBRACE && st.brace_level != LEVEL_MAX) begin
                st.brace_level++;
              end else if (b == CH_RBRACE && st.brace_level != 0) begin
                st.brace_level--;
              end else if (b == CH_LBRACK && st.bracket_level != LEVEL_MAX) begin
                st.bracket_level++;
              end else if (b == CH_RBRACK && st.bracket_level != 0) begin
                st.bracket_level--;
              end
            end
            st.last_byte = b;
            if (!st.quoted && st.brace_level == 0 && st.bracket_level == 0) begin
              res.event_res = EV_JSON;
              st = '0;
            end
          end
        end
      end
      res.frame_mode = st.mode;
      due_results.push_back(res);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compares one accepted result with the oldest one still due.
    function void check_result(frame_result_t got);
      frame_result_t want;
      if (due_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual event %0d", $time,
                 got.event_res);
        return;
      end
      want = due_results.pop_front();
      compare_field("event_res", want.event_res, got.event_res);
      compare_field("byte_kept", want.byte_kept, got.byte_kept);
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("frame_length", want.frame_length, got.frame_length);
      compare_field("frame_mode", want.frame_mode, got.frame_mode);
    endfunction
  endclass

  typedef struct packed {
    logic       act;
    logic [7:0] b;
  } rx_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = ACT_BYTE;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  event_res;
  logic        byte_kept;
  logic [7:0]  data_byte;
  logic [10:0] frame_length;
  logic [1:0]  frame_mode;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_TIMEOUT;
  logic [15:0] cfg_data = 16'h0000;

  frame_event_board board = new();
  rx_item_t stim_q[$];
  int  idle_cycles = 0;
  int  tick_span = 4;
  int  take_stall;
  bit  send_rush = 1'b0;
  bit  take_rush = 1'b0;

  line_or_json_frame_detector_unit u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_res(event_res),
    .byte_kept(byte_kept),
    .data_byte(data_byte),
    .frame_length(frame_length),
    .frame_mode(frame_mode),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Check results before noting new input so the oldest expectation is compared.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        board.check_result(frame_result_t'({event_res, byte_kept, data_byte, frame_length,
                                            frame_mode}));
      end
      if (in_valid && in_ready) begin
        board.note_item(action, rx_byte);
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stalls with occasional stretches of constant readiness.
  initial begin
    wait (!rst);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) take_rush = !take_rush;
      take_stall = take_rush ? 0 : $urandom_range(0, 10);
      if (take_stall > 0) begin
        out_ready <= 1'b0;
        repeat (take_stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  function automatic void put_byte(logic [7:0] b);
    stim_q.push_back({ACT_BYTE, b});
  endfunction

  // The byte lane carries junk during a tick; the block must ignore it.
  function automatic void put_ticks(int n);
    for (int i = 0; i < n; i++) stim_q.push_back({ACT_TICK, 8'($urandom)});
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick_letter();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'h30, 8'h39))
                                       : 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic void put_blanks(int most);
    int n;
    n = $urandom_range(0, most);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: put_byte(CH_SPACE);
        1: put_byte(CH_TAB);
        2: put_byte(CH_LF);
        3: put_byte(8'h0B);
        4: put_byte(8'h0C);
        default: put_byte(CH_CR);
      endcase
    end
  endfunction

  // A quoted string with escapes and framing characters inside it.
  function automatic void put_string();
    int n;
    n = $urandom_range(0, 6);
    put_byte(CH_QUOTE);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: begin
          put_byte(CH_BSLASH);
          put_byte(($urandom_range(0, 1) == 0) ? CH_QUOTE : pick_letter());
        end
        1: put_byte(CH_RBRACE);
        2: put_byte(CH_LBRACK);
        default: put_byte(pick_letter());
      endcase
    end
    put_byte(CH_QUOTE);
  endfunction

  // A text line; brackets after the first byte must not switch it to JSON.
  function automatic void add_line();
    int n;
    n = $urandom_range(0, 15);
    put_blanks(2);
    put_byte(($urandom_range(0, 4) == 0) ? CH_RBRACE : pick_letter());
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: put_byte(CH_CR);
        1: put_ticks(1);
        2: put_byte(($urandom_range(0, 1) == 0) ? CH_LBRACE : CH_QUOTE);
        default: put_byte(pick_letter());
      endcase
    end
    put_byte(CH_LF);
  endfunction

  // A nested JSON document; a cut-off one is followed by idle ticks instead of closers.
  function automatic void add_json(bit cut);
    logic [7:0] closers[$];
    int steps;
    steps = $urandom_range(1, 24);
    put_blanks(2);
    if ($urandom_range(0, 1) == 0) begin
      put_byte(CH_LBRACE);
      closers.push_back(CH_RBRACE);
    end else begin
      put_byte(CH_LBRACK);
      closers.push_back(CH_RBRACK);
    end
    for (int i = 0; i < steps; i++) begin
      case ($urandom_range(0, 11))
        0, 1: begin
          if (closers.size() < 6) begin
            if ($urandom_range(0, 1) == 0) begin
              put_byte(CH_LBRACE);
              closers.push_back(CH_RBRACE);
            end else begin
              put_byte(CH_LBRACK);
              closers.push_back(CH_RBRACK);
            end
          end
        end
        2: if (closers.size() > 1) put_byte(closers.pop_back());
        3, 4: put_string();
        5: begin
          put_byte(pick_letter());
          put_byte(pick_letter());
        end
        6: put_byte(($urandom_range(0, 1) == 0) ? 8'h3A : 8'h2C);
        7: put_blanks(3);
        8: put_ticks($urandom_range(1, tick_span));
        9: put_byte(8'($urandom_range(0, 255)));
        default: put_byte(pick_letter());
      endcase
    end
    if (cut) begin
      put_ticks($urandom_range(1, tick_span + 2));
    end else begin
      while (closers.size() != 0) put_byte(closers.pop_back());
    end
  endfunction

  function automatic void fill_phase(int target);
    while (stim_q.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: add_json(1'b0);
        4, 5, 6: add_line();
        7: for (int i = $urandom_range(1, 6); i > 0; i--) put_byte(8'($urandom));
        8: put_ticks($urandom_range(1, 12));
        default: add_json(1'b1);
      endcase
    end
  endfunction

  task automatic send_item(rx_item_t it);
    int gap;
    if ($urandom_range(0, 19) == 0) send_rush = !send_rush;
    gap = send_rush ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= it.act;
    rx_byte <= it.b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sends everything queued, then waits for the block to go quiet.
  task automatic drain();
    while (stim_q.size() != 0) send_item(stim_q.pop_front());
    in_valid <= 1'b0;
    while (board.due_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_regs(logic [15:0] ticks, logic [10:0] lim);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TIMEOUT;
    cfg_data <= ticks;
    board.set_reg(CFG_TIMEOUT, ticks);
    @(negedge clk);
    cfg_index <= CFG_LIMIT;
    cfg_data <= {5'd0, lim};
    board.set_reg(CFG_LIMIT, {5'd0, lim});
    @(negedge clk);
    cfg_we <= 1'b0;
    tick_span = (ticks < 12) ? int'(ticks) + 2 : 4;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: whitespace, CR, a line, escapes, depth floor and raw bytes.
    put_ticks(1);
    put_text(" \t\r\n");
    put_byte(8'h0B);
    put_byte(8'h0C);
    put_text("x\n");
    put_text("[}\"\\\"]\"]");
    put_text("{");
    put_ticks(1);
    put_text("}");
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(CH_LF);
    fill_phase(220);
    drain();

    // Tightest settings: a timeout on the second idle tick and overflow on the second byte.
    set_regs(16'd1, 11'd1);
    put_text("{");
    put_ticks(2);
    put_text("ab");
    fill_phase(150);
    drain();

    // Widest settings.
    set_regs(16'hFFFF, 11'd2047);
    fill_phase(150);
    drain();

    set_regs(16'd3, 11'd24);
    fill_phase(220);
    drain();

    set_regs(16'($urandom_range(1, 8)), 11'($urandom_range(4, 80)));
    fill_phase(220);
    drain();

    set_regs(16'd1, 11'd2047);
    fill_phase(150);
    drain();

    set_regs(16'($urandom_range(2, 10)), 11'($urandom_range(6, 60)));
    fill_phase(200);
    drain();

    if (board.mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
